// ----- hw/rtl/drh_pkg.sv -----
package drh_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned OrdW   = 32;
  localparam int unsigned RevW   = 32;
  localparam int unsigned TriesW = 16;
  localparam int unsigned AmtW   = 32;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    ACT_ADVANCE = 2'd0,
    ACT_QUEUE   = 2'd1,
    ACT_CANCEL  = 2'd2,
    ACT_POP     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_e;

  // request payload carried along with each key
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [RevW-1:0]   rev;
    logic [TriesW-1:0] tries;
  } pay_t;

  // one-cycle commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rm;
  } ctl_t;

endpackage

// ----- hw/rtl/drh_cell.sv -----
module drh_cell #(
  parameter int unsigned TimeBits = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  drh_pkg::ctl_t               ctl_i,
  input  logic [TimeBits-1:0]         new_due_i,
  input  logic [drh_pkg::OrdW-1:0]    new_ord_i,
  input  drh_pkg::pay_t               new_pay_i,
  input  logic [TimeBits-1:0]         rm_due_i,
  input  logic [drh_pkg::OrdW-1:0]    rm_ord_i,
  input  logic                        left_valid_i,
  input  logic [TimeBits-1:0]         left_due_i,
  input  logic [drh_pkg::OrdW-1:0]    left_ord_i,
  input  drh_pkg::pay_t               left_pay_i,
  input  logic                        left_lt_i,
  input  logic                        right_valid_i,
  input  logic [TimeBits-1:0]         right_due_i,
  input  logic [drh_pkg::OrdW-1:0]    right_ord_i,
  input  drh_pkg::pay_t               right_pay_i,
  output logic                        valid_o,
  output logic [TimeBits-1:0]         due_o,
  output logic [drh_pkg::OrdW-1:0]    ord_o,
  output drh_pkg::pay_t               pay_o,
  output logic                        lt_o
);

  logic                     valid_q, valid_d;
  logic [TimeBits-1:0]      due_q, due_d;
  logic [drh_pkg::OrdW-1:0] ord_q, ord_d;
  drh_pkg::pay_t            pay_q, pay_d;
  logic                     lt, ge;

  // new key sorts ahead of this cell (an empty cell counts as later)
  assign lt = !valid_q || (new_due_i < due_q) || ((new_due_i == due_q) && (new_ord_i < ord_q));
  // this cell is at or behind the removed entry
  assign ge = valid_q && !((due_q < rm_due_i) || ((due_q == rm_due_i) && (ord_q < rm_ord_i)));

  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    ord_d   = ord_q;
    pay_d   = pay_q;
    if (ctl_i.ins && lt) begin
      if (left_lt_i) begin
        valid_d = left_valid_i;
        due_d   = left_due_i;
        ord_d   = left_ord_i;
        pay_d   = left_pay_i;
      end else begin
        valid_d = 1'b1;
        due_d   = new_due_i;
        ord_d   = new_ord_i;
        pay_d   = new_pay_i;
      end
    end else if (ctl_i.rm && ge) begin
      valid_d = right_valid_i;
      due_d   = right_due_i;
      ord_d   = right_ord_i;
      pay_d   = right_pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    ord_q <= ord_d;
    pay_q <= pay_d;
  end

  assign valid_o = valid_q;
  assign due_o   = due_q;
  assign ord_o   = ord_q;
  assign pay_o   = pay_q;
  assign lt_o    = lt;

endmodule

// ----- hw/rtl/deadline_request_heap.sv -----
// deadline request queue: holds at most one pending request per client id, always kept
// sorted by due time and then by issue number in a row of cells, earliest in cell 0.
// every cell compares a broadcast key with its own and shifts one place towards or away
// from its neighbour, so an insert or a removal moves the whole row at once whatever the fill.
// from acceptance to the result register an item passes through the search state and then
// the done state for advance, for a pop that grants nothing and for a cancel that finds no
// request; a granted pop and a cancel that finds a request go through search, shift and
// done; a queue of an id with nothing pending goes through search, insert and done; a
// queue that replaces a request goes through search, shift, insert and done. the item
// also waits in the done state while a stalled receiver still holds the result register.
// a new item is taken only in the cycle after the previous one has gone to the result
// register, so no item is taken before the last one is through. time and due times
// saturate at all ones; ids at or above CLIENTS are ignored by queue and cancel.
module deadline_request_heap #(
  parameter int unsigned CLIENTS   = 256,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [drh_pkg::IdW-1:0]       client_id_i,
  input  logic signed [drh_pkg::AmtW-1:0] amount_ticks_i,
  input  logic [drh_pkg::RevW-1:0]      tag_revision_i,
  input  logic [drh_pkg::TriesW-1:0]    tries_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [drh_pkg::IdW-1:0]       out_client_o,
  output logic [drh_pkg::RevW-1:0]      out_revision_o,
  output logic [drh_pkg::TriesW-1:0]    out_tries_o,
  output logic [drh_pkg::CountW-1:0]    pending_count_o
);

  localparam int unsigned CW = $clog2(CLIENTS + 1);
  localparam int unsigned KW = TIME_BITS + drh_pkg::OrdW;

  // cell row
  logic                     c_valid [CLIENTS];
  logic [TIME_BITS-1:0]     c_due   [CLIENTS];
  logic [drh_pkg::OrdW-1:0] c_ord   [CLIENTS];
  drh_pkg::pay_t            c_pay   [CLIENTS];
  logic                     c_lt    [CLIENTS];

  drh_pkg::state_e          state_q, state_d;
  drh_pkg::ctl_t            ctl;

  // latched item
  drh_pkg::action_e         act_q;
  logic [drh_pkg::IdW-1:0]  id_q;
  logic [drh_pkg::AmtW-2:0] amt_q;
  logic [drh_pkg::RevW-1:0] rev_q;
  logic [drh_pkg::TriesW-1:0] tries_q;

  logic [TIME_BITS-1:0]     time_q;
  logic [drh_pkg::OrdW-1:0] order_q;
  logic [CW-1:0]            count_q;
  logic [TIME_BITS-1:0]     rm_due_q;
  logic [drh_pkg::OrdW-1:0] rm_ord_q;

  // result being built, and result register
  logic                     res_gr_q;
  drh_pkg::pay_t            res_pay_q;
  logic                     out_valid_q;
  logic                     out_gr_q;
  drh_pkg::pay_t            out_pay_q;
  logic [CW-1:0]            out_count_q;

  logic                     accept, id_ok, head_due, hit_any, out_free;
  logic [drh_pkg::AmtW-2:0] in_amt;
  logic [TIME_BITS:0]       sum;
  logic [TIME_BITS-1:0]     sat_time;
  logic [KW-1:0]            hit_key;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != drh_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign id_ok    = (32'(id_q) < CLIENTS);
  // negative amounts count as zero
  assign in_amt   = amount_ticks_i[drh_pkg::AmtW-1] ? '0 : amount_ticks_i[drh_pkg::AmtW-2:0];
  assign sum      = {1'b0, time_q} + (TIME_BITS+1)'(amt_q);
  assign sat_time = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign head_due = c_valid[0] && (c_due[0] <= time_q);

  // one-hot select of the cell that holds the searched id
  always_comb begin
    hit_any = 1'b0;
    hit_key = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      if (c_valid[i] && (c_pay[i].id == id_q)) begin
        hit_any = 1'b1;
        hit_key = hit_key | {c_due[i], c_ord[i]};
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drh_pkg::S_IDLE: begin
        if (accept) state_d = drh_pkg::S_FIND;
      end
      drh_pkg::S_FIND: begin
        priority if (act_q == drh_pkg::ACT_ADVANCE) state_d = drh_pkg::S_DONE;
        else if (act_q == drh_pkg::ACT_POP) state_d = head_due ? drh_pkg::S_SHIFT : drh_pkg::S_DONE;
        else if (!id_ok) state_d = drh_pkg::S_DONE;
        else if (hit_any) state_d = drh_pkg::S_SHIFT;
        else if (act_q == drh_pkg::ACT_QUEUE) state_d = drh_pkg::S_INSERT;
        else state_d = drh_pkg::S_DONE;
      end
      drh_pkg::S_SHIFT: begin
        state_d = (act_q == drh_pkg::ACT_QUEUE) ? drh_pkg::S_INSERT : drh_pkg::S_DONE;
      end
      drh_pkg::S_INSERT: state_d = drh_pkg::S_DONE;
      drh_pkg::S_DONE: begin
        if (out_free) state_d = drh_pkg::S_IDLE;
      end
      default: state_d = drh_pkg::S_IDLE;
    endcase
  end

  // cell commands
  always_comb begin
    ctl.rm  = (state_q == drh_pkg::S_SHIFT);
    ctl.ins = (state_q == drh_pkg::S_INSERT) && (count_q < CW'(CLIENTS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drh_pkg::S_IDLE;
      time_q      <= '0;
      order_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      res_gr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) res_gr_q <= 1'b0;
      if (state_q == drh_pkg::S_FIND) begin
        if (act_q == drh_pkg::ACT_ADVANCE) time_q <= sat_time;
        if (act_q == drh_pkg::ACT_POP && head_due) begin
          res_gr_q <= 1'b1;
          count_q  <= count_q - 1'b1;
        end else if ((act_q == drh_pkg::ACT_QUEUE || act_q == drh_pkg::ACT_CANCEL)
                     && id_ok && hit_any) begin
          count_q  <= count_q - 1'b1;
        end
      end
      if (state_q == drh_pkg::S_INSERT) begin
        order_q <= order_q + 1'b1;
        if (ctl.ins) count_q <= count_q + 1'b1;
      end
      if (state_q == drh_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= drh_pkg::action_e'(action_i);
      id_q    <= client_id_i;
      amt_q   <= in_amt;
      rev_q   <= tag_revision_i;
      tries_q <= tries_i;
    end
    if (state_q == drh_pkg::S_FIND) begin
      if (act_q == drh_pkg::ACT_POP) begin
        rm_due_q  <= c_due[0];
        rm_ord_q  <= c_ord[0];
        res_pay_q <= c_pay[0];
      end else begin
        rm_due_q <= hit_key[KW-1:drh_pkg::OrdW];
        rm_ord_q <= hit_key[drh_pkg::OrdW-1:0];
      end
    end
    if (state_q == drh_pkg::S_DONE && out_free) begin
      out_gr_q    <= res_gr_q;
      out_pay_q   <= res_gr_q ? res_pay_q : '0;
      out_count_q <= count_q;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CLIENTS; g++) begin : g_cell
      logic                     lv, rv, llt;
      logic [TIME_BITS-1:0]     ld, rd;
      logic [drh_pkg::OrdW-1:0] lo, ro;
      drh_pkg::pay_t            lp, rp;
      if (g == 0) begin : g_first
        assign lv = 1'b0; assign ld = '0; assign lo = '0; assign lp = '0; assign llt = 1'b0;
      end else begin : g_mid
        assign lv = c_valid[g-1]; assign ld = c_due[g-1]; assign lo = c_ord[g-1];
        assign lp = c_pay[g-1]; assign llt = c_lt[g-1];
      end
      if (g == CLIENTS - 1) begin : g_last
        assign rv = 1'b0; assign rd = '0; assign ro = '0; assign rp = '0;
      end else begin : g_body
        assign rv = c_valid[g+1]; assign rd = c_due[g+1]; assign ro = c_ord[g+1];
        assign rp = c_pay[g+1];
      end
      drh_cell #(.TimeBits(TIME_BITS)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .new_due_i    (sat_time),
        .new_ord_i    (order_q),
        .new_pay_i    ({id_q, rev_q, tries_q}),
        .rm_due_i     (rm_due_q),
        .rm_ord_i     (rm_ord_q),
        .left_valid_i (lv),
        .left_due_i   (ld),
        .left_ord_i   (lo),
        .left_pay_i   (lp),
        .left_lt_i    (llt),
        .right_valid_i(rv),
        .right_due_i  (rd),
        .right_ord_i  (ro),
        .right_pay_i  (rp),
        .valid_o      (c_valid[g]),
        .due_o        (c_due[g]),
        .ord_o        (c_ord[g]),
        .pay_o        (c_pay[g]),
        .lt_o         (c_lt[g])
      );
    end
  endgenerate

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_gr_q;
  assign out_client_o    = out_pay_q.id;
  assign out_revision_o  = out_pay_q.rev;
  assign out_tries_o     = out_pay_q.tries;
  assign pending_count_o = drh_pkg::CountW'(out_count_q);

endmodule

// ----- tb/deadline_request_heap_tb.sv -----
module deadline_request_heap_tb;

  localparam int unsigned NCLI = 256;
  localparam logic [47:0] TMAX = {48{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = '0;
  logic [drh_pkg::IdW-1:0] client_id_i = '0;
  logic signed [drh_pkg::AmtW-1:0] amount_ticks_i = '0;
  logic [drh_pkg::RevW-1:0] tag_revision_i = '0;
  logic [drh_pkg::TriesW-1:0] tries_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic granted_o;
  logic [drh_pkg::IdW-1:0] out_client_o;
  logic [drh_pkg::RevW-1:0] out_revision_o;
  logic [drh_pkg::TriesW-1:0] out_tries_o;
  logic [drh_pkg::CountW-1:0] pending_count_o;

  deadline_request_heap dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted view of the queue
  typedef struct packed {
    logic                       granted;
    logic [drh_pkg::IdW-1:0]    client;
    logic [drh_pkg::RevW-1:0]   rev;
    logic [drh_pkg::TriesW-1:0] tries;
    logic [drh_pkg::CountW-1:0] count;
  } grant_t;

  int          heap_id [NCLI];
  int          pos_of [NCLI];
  logic        queued [NCLI];
  logic [47:0] due_at [NCLI];
  logic [31:0] seq_no [NCLI];
  logic [31:0] rev_of [NCLI];
  logic [15:0] tries_of [NCLI];
  int          fill;
  logic [47:0] now_t;
  logic [31:0] seq_next;

  grant_t grant_q[$];
  int mismatches = 0;
  bit quiet = 1'b0;  // no idling in the final stretch

  function automatic logic [47:0] sat_sum(logic [47:0] t, logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic bit sooner(int a, int b);
    if (due_at[a] != due_at[b]) return due_at[a] < due_at[b];
    return seq_no[a] < seq_no[b];
  endfunction

  function automatic void place(int p, int id);
    heap_id[p] = id;
    pos_of[id] = p;
  endfunction

  function automatic void bubble_up(int p);
    int a, b;
    while (p > 0) begin
      a = heap_id[p];
      b = heap_id[(p - 1) / 2];
      if (!sooner(a, b)) break;
      place(p, b);
      place((p - 1) / 2, a);
      p = (p - 1) / 2;
    end
  endfunction

  function automatic void bubble_down(int p);
    int l, m, a;
    forever begin
      l = 2 * p + 1;
      if (l >= fill) return;
      m = l;
      if (l + 1 < fill && sooner(heap_id[l + 1], heap_id[l])) m = l + 1;
      if (!sooner(heap_id[m], heap_id[p])) return;
      a = heap_id[p];
      place(p, heap_id[m]);
      place(m, a);
      p = m;
    end
  endfunction

  function automatic void drop_at(int p);
    int id;
    if (fill == 0 || p >= fill) return;
    fill--;
    if (p == fill) return;
    id = heap_id[fill];
    place(p, id);
    if (p > 0 && sooner(id, heap_id[(p - 1) / 2])) bubble_up(p);
    else bubble_down(p);
  endfunction

  function automatic void withdraw(int id);
    if (!queued[id]) return;
    drop_at(pos_of[id]);
    queued[id] = 1'b0;
  endfunction

  function automatic grant_t next_grant(drh_pkg::action_e act, logic [7:0] id,
                                        logic [31:0] amt, logic [31:0] rev, logic [15:0] tr);
    grant_t g;
    logic [31:0] d;
    int top;
    g = '0;
    d = amt[31] ? 32'd0 : amt;
    case (act)
      drh_pkg::ACT_ADVANCE: now_t = sat_sum(now_t, d);
      drh_pkg::ACT_QUEUE: begin
        withdraw(int'(id));
        due_at[id] = sat_sum(now_t, d);
        seq_no[id] = seq_next;
        seq_next++;
        rev_of[id] = rev;
        tries_of[id] = tr;
        queued[id] = 1'b1;
        place(fill, int'(id));
        fill++;
        bubble_up(fill - 1);
      end
      drh_pkg::ACT_CANCEL: withdraw(int'(id));
      default: begin
        if (fill > 0) begin
          top = heap_id[0];
          if (due_at[top] <= now_t) begin
            g.granted = 1'b1;
            g.client = 8'(top);
            g.rev = rev_of[top];
            g.tries = tries_of[top];
            drop_at(0);
            queued[top] = 1'b0;
          end
        end
      end
    endcase
    g.count = drh_pkg::CountW'(fill);
    return g;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk_i);
  endtask

  // drive one item and hold it until taken
  task automatic send_item(drh_pkg::action_e act, logic [7:0] id, logic [31:0] amt,
                           logic [31:0] rev, logic [15:0] tr);
    grant_t g;
    idle_gap();
    action_i = act;
    client_id_i = id;
    amount_ticks_i = amt;
    tag_revision_i = rev;
    tries_i = tr;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = next_grant(act, id, amt, rev, tr);
    grant_q.insert(grant_q.size(), g);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    grant_t exp_g, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {granted_o, out_client_o, out_revision_o, out_tries_o, pending_count_o};
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_g = grant_q.pop_front();
        if (got !== exp_g) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp g=%b id=%h rev=%h tr=%h n=%0d",
                      " got g=%b id=%h rev=%h tr=%h n=%0d"},
                     exp_g.granted, exp_g.client, exp_g.rev, exp_g.tries, exp_g.count,
                     got.granted, got.client, got.rev, got.tries, got.count);
        end
      end
    end
  end

  function automatic logic [31:0] rand_amt();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return -$urandom_range(1, 100);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic test_directed();
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);               // pop on empty
    send_item(drh_pkg::ACT_CANCEL, 8'd9, 0, 0, 0);         // cancel with nothing pending
    send_item(drh_pkg::ACT_QUEUE, 8'd0, 32'd5, '1, '1);
    send_item(drh_pkg::ACT_QUEUE, 8'd255, 32'h80000000, '0, '0);  // negative delay clamps
    send_item(drh_pkg::ACT_QUEUE, 8'd7, 32'd0, 32'h5a5a5a5a, 16'h1234);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);               // not yet due
    send_item(drh_pkg::ACT_ADVANCE, 0, -32'sd3, 0, 0);     // negative advance ignored
    send_item(drh_pkg::ACT_QUEUE, 8'd0, 32'd1, 32'h1, 16'h2);  // requeue replaces
    send_item(drh_pkg::ACT_ADVANCE, 0, 32'd1, 0, 0);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
    send_item(drh_pkg::ACT_QUEUE, 8'd3, 32'd2, 0, 0);
    send_item(drh_pkg::ACT_CANCEL, 8'd3, 0, 0, 0);
    // large time steps, then a far deadline on top of them
    repeat (4) send_item(drh_pkg::ACT_ADVANCE, 0, 32'h7fffffff, 0, 0);
    send_item(drh_pkg::ACT_QUEUE, 8'd4, 32'h7fffffff, 0, 0);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);               // not yet due
    send_item(drh_pkg::ACT_ADVANCE, 0, 32'h7fffffff, 0, 0);
    send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    int n;
    logic [7:0] id;
    n = 0;
    while (n < 1350) begin
      if (n > 1150) quiet = 1'b1;
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1:    send_item(drh_pkg::ACT_ADVANCE, 0, rand_amt(), 0, 0);
        2, 3, 4: send_item(drh_pkg::ACT_QUEUE, id, rand_amt(), $urandom, 16'($urandom));
        5:       send_item(drh_pkg::ACT_CANCEL, id, 0, 0, 0);
        default: send_item(drh_pkg::ACT_POP, id, $urandom, $urandom, 16'($urandom));
      endcase
      n++;
    end
  endtask

  // fill all 256 ids, requeue one while full, then drain in order
  task automatic test_full_heap();
    for (int i = 0; i < NCLI; i++)
      send_item(drh_pkg::ACT_QUEUE, 8'(i), $urandom_range(0, 3), $urandom, 16'($urandom));
    send_item(drh_pkg::ACT_QUEUE, 8'd5, 32'd1, 32'hcafe, 16'h55);
    send_item(drh_pkg::ACT_ADVANCE, 0, 32'd4, 0, 0);
    for (int i = 0; i < NCLI + 2; i++) send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
  endtask

  initial begin
    fill = 0;
    now_t = '0;
    seq_next = '0;
    for (int i = 0; i < NCLI; i++) queued[i] = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    // empty the queue before the full-heap test
    while (fill > 0) begin
      send_item(drh_pkg::ACT_ADVANCE, 0, 32'h7fffffff, 0, 0);
      send_item(drh_pkg::ACT_POP, 0, 0, 0, 0);
    end
    test_full_heap();
    test_random();
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
